>>> design/skt_pkg.sv
// Package: widths, codes and shared types of the sorted key table.
`default_nettype none
package skt_pkg;

  localparam int KEY_W   = 32;
  localparam int PAY_W   = 17;
  localparam int ENTRY_W = KEY_W + PAY_W;
  localparam int IDX_W   = 7;   // width of position and entry_total fields

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;
  localparam logic [1:0] MODE_MODIFY = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;

  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [3:0] FLOOR_MAX = 4'd8;

  // request as latched by the sequencer
  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;
    logic             fields_ok;
    logic [PAY_W-1:0] payload;
  } skt_req_t;

  // result handed from the sequencer to the output register
  typedef struct packed {
    logic [2:0]       status;
    logic [IDX_W-1:0] position;
    logic [IDX_W-1:0] entry_total;
    logic             report;
    logic [PAY_W-1:0] payload;
  } skt_result_t;

  // building code back to its ASCII letter
  function automatic logic [7:0] building_letter(input logic [1:0] code);
    logic [7:0] ch;
    case (code)
      2'd0:    ch = CH_A;
      2'd1:    ch = CH_B;
      2'd2:    ch = CH_C;
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

>>> design/skt_req_if.sv
// Request channel: valid/ready handshake with one table request.
`default_nettype none
interface skt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] key;
  logic [7:0]  building_char;
  logic [3:0]  floor;
  logic [6:0]  room;
  logic [1:0]  kind;
  logic [1:0]  availability;

  modport source (output valid, mode, key, building_char, floor, room, kind, availability,
                  input ready);
  modport sink   (input valid, mode, key, building_char, floor, room, kind, availability,
                  output ready);
endinterface
`default_nettype wire

>>> design/skt_rsp_if.sv
// Response channel: valid/ready handshake with one table result.
`default_nettype none
interface skt_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [6:0] position;
  logic [6:0] entry_total;
  logic [7:0] found_building;
  logic [3:0] found_floor;
  logic [6:0] found_room;
  logic [1:0] found_kind;
  logic [1:0] found_availability;

  modport source (output valid, status, position, entry_total, found_building, found_floor,
                         found_room, found_kind, found_availability,
                  input ready);
  modport sink   (input valid, status, position, entry_total, found_building, found_floor,
                        found_room, found_kind, found_availability,
                  output ready);
endinterface
`default_nettype wire

>>> design/skt_fields.sv
// Field check and record packing for an incoming request.
`default_nettype none
module skt_fields (
  input  logic [7:0]                building_char,
  input  logic [3:0]                floor,
  input  logic [6:0]                room,
  input  logic [1:0]                kind,
  input  logic [1:0]                availability,
  output logic                      fields_ok,
  output logic [skt_pkg::PAY_W-1:0] payload
);
  import skt_pkg::*;

  logic [7:0] bofs;

  assign bofs      = building_char - CH_A;
  assign fields_ok = ((building_char == CH_A) || (building_char == CH_B) ||
                      (building_char == CH_C)) && (floor <= FLOOR_MAX);
  // layout: building code, floor, room, kind, availability
  assign payload   = fields_ok ? {bofs[1:0], floor, room, kind, availability}
                               : {PAY_W{1'b0}};
endmodule
`default_nettype wire

>>> design/skt_ctrl.sv
// Sequencer with the entry memory: binary search, then on insert or delete shift one entry a cycle.
`default_nettype none
module skt_ctrl #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  skt_pkg::skt_req_t    req_in,
  output logic                 idle,
  output logic                 done,
  input  logic                 taken,
  output skt_pkg::skt_result_t res
);
  import skt_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = $clog2(TABLE_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PROBE = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_ACT   = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rdata;
  logic [AW-1:0]      raddr, waddr;
  logic [ENTRY_W-1:0] wdata;
  logic               we;

  logic [2:0]       state, state_next;
  skt_req_t         rq, rq_next;
  logic [CW-1:0]    count, count_next;
  logic [CW-1:0]    lo, lo_next, hi, hi_next, mid, mid_next, mid_calc;
  logic [CW-1:0]    pos, pos_next, cur, cur_next, cur_m1;
  logic [CW-1:0]    pend_addr, pend_addr_next;
  logic             pend, pend_next;
  logic             hit, hit_next;
  logic             dir_up, dir_up_next;
  logic [PAY_W-1:0] hit_pay, hit_pay_next;
  logic [2:0]       status, status_next;
  logic             rep, rep_next;
  logic [PAY_W-1:0] rep_pay, rep_pay_next;
  logic [KEY_W-1:0] rkey;

  assign mid_calc = lo + ((hi - lo) >> 1);
  assign cur_m1   = cur - CW'(1);
  assign rkey     = rdata[ENTRY_W-1:PAY_W];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_comb begin
    state_next     = state;
    rq_next        = rq;
    count_next     = count;
    lo_next        = lo;
    hi_next        = hi;
    mid_next       = mid;
    pos_next       = pos;
    cur_next       = cur;
    pend_next      = pend;
    pend_addr_next = pend_addr;
    hit_next       = hit;
    dir_up_next    = dir_up;
    hit_pay_next   = hit_pay;
    status_next    = status;
    rep_next       = rep;
    rep_pay_next   = rep_pay;
    raddr          = mid[AW-1:0];
    we             = 1'b0;
    waddr          = pend_addr[AW-1:0];
    wdata          = rdata;
    idle           = 1'b0;
    done           = 1'b0;
    case (state)
      S_IDLE: begin
        idle = 1'b1;
        if (start) begin
          rq_next    = req_in;
          lo_next    = '0;
          hi_next    = count;
          hit_next   = 1'b0;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (lo < hi) begin
          mid_next   = mid_calc;
          raddr      = mid_calc[AW-1:0];
          state_next = S_CMP;
        end else begin
          pos_next   = lo;
          state_next = S_ACT;
        end
      end
      S_CMP: begin
        if (rkey == rq.key) begin
          hit_next     = 1'b1;
          pos_next     = mid;
          hit_pay_next = rdata[PAY_W-1:0];
          state_next   = S_ACT;
        end else begin
          if (rq.key < rkey) hi_next = mid;
          else               lo_next = mid + CW'(1);
          state_next = S_PROBE;
        end
      end
      S_ACT: begin
        status_next  = ST_OK;
        rep_next     = 1'b0;
        rep_pay_next = hit_pay;
        state_next   = S_RESP;
        case (rq.mode)
          MODE_LOOKUP: begin
            if (hit) rep_next = 1'b1;
            else     status_next = ST_NOT_FOUND;
          end
          MODE_INSERT: begin
            if (hit) begin
              status_next = ST_DUPLICATE;
              rep_next    = 1'b1;
            end else if (!rq.fields_ok) begin
              status_next = ST_INVALID;
            end else if (count == CW'(TABLE_DEPTH)) begin
              status_next = ST_FULL;
            end else begin
              rep_next     = 1'b1;
              rep_pay_next = rq.payload;
              cur_next     = count;
              pend_next    = 1'b0;
              dir_up_next  = 1'b1;
              state_next   = S_SHIFT;
            end
          end
          MODE_DELETE: begin
            if (!hit) begin
              status_next = ST_NOT_FOUND;
            end else begin
              rep_next    = 1'b1;
              cur_next    = pos + CW'(1);
              pend_next   = 1'b0;
              dir_up_next = 1'b0;
              state_next  = S_SHIFT;
            end
          end
          default: begin
            if (!hit) begin
              status_next = ST_NOT_FOUND;
            end else if (!rq.fields_ok) begin
              status_next = ST_INVALID;
              rep_next    = 1'b1;
            end else begin
              rep_next     = 1'b1;
              rep_pay_next = rq.payload;
              we           = 1'b1;
              waddr        = pos[AW-1:0];
              wdata        = {rq.key, rq.payload};
            end
          end
        endcase
      end
      S_SHIFT: begin
        // one read issued and the previous read written back each cycle
        we = pend;
        if (dir_up) begin
          if (cur > pos) begin
            raddr          = cur_m1[AW-1:0];
            pend_next      = 1'b1;
            pend_addr_next = cur;
            cur_next       = cur_m1;
          end else begin
            pend_next = 1'b0;
            if (!pend) begin
              we         = 1'b1;
              waddr      = pos[AW-1:0];
              wdata      = {rq.key, rq.payload};
              count_next = count + CW'(1);
              state_next = S_RESP;
            end
          end
        end else begin
          if (cur < count) begin
            raddr          = cur[AW-1:0];
            pend_next      = 1'b1;
            pend_addr_next = cur_m1;
            cur_next       = cur + CW'(1);
          end else begin
            pend_next = 1'b0;
            if (!pend) begin
              count_next = count - CW'(1);
              state_next = S_RESP;
            end
          end
        end
      end
      S_RESP: begin
        done = 1'b1;
        if (taken) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
    rq        <= rq_next;
    lo        <= lo_next;
    hi        <= hi_next;
    mid       <= mid_next;
    pos       <= pos_next;
    cur       <= cur_next;
    pend_addr <= pend_addr_next;
    hit       <= hit_next;
    dir_up    <= dir_up_next;
    hit_pay   <= hit_pay_next;
    status    <= status_next;
    rep       <= rep_next;
    rep_pay   <= rep_pay_next;
  end

  assign res.status      = status;
  assign res.position    = IDX_W'(pos);
  assign res.entry_total = IDX_W'(count);
  assign res.report      = rep;
  assign res.payload     = rep_pay;
endmodule
`default_nettype wire

>>> design/sorted_key_table.sv
// Top level: sorted key table with request and response channels.
//
// Keeps up to TABLE_DEPTH records in ascending order of a 32-bit key.
// Requests arrive on req (valid/ready): lookup, insert, delete or modify.
// Each request gives exactly one transfer on rsp with a status, the match
// index or insertion point, the entry count after the request and the
// fields of the matched (or newly written) record.
// One request at a time; req.ready is high only while idle. A search
// makes at most ceil(log2(count+1)) probes, 7 for a full table; each probe
// is a registered read plus a compare. A successful insert or delete then
// moves the entries behind the slot, one read and one write of the entry
// memory per cycle.
// The result sits in an output register, so a new request is taken while
// the last result still waits on a stalled rsp; a second finished result
// waits in the sequencer until that register frees up.
// Reset (rst, synchronous) empties the table and drops rsp.valid; stored
// entries are not cleared, only the count.
`default_nettype none
module sorted_key_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  skt_req_if.sink   req,
  skt_rsp_if.source rsp
);
  import skt_pkg::*;

  logic             fields_ok;
  logic [PAY_W-1:0] payload;
  skt_req_t         req_in;
  skt_result_t      res;
  logic             idle, done, taken;

  skt_fields u_fields (
    .building_char (req.building_char),
    .floor         (req.floor),
    .room          (req.room),
    .kind          (req.kind),
    .availability  (req.availability),
    .fields_ok     (fields_ok),
    .payload       (payload)
  );

  assign req_in.mode      = req.mode;
  assign req_in.key       = req.key;
  assign req_in.fields_ok = fields_ok;
  assign req_in.payload   = payload;

  // no request is taken while reset is held
  assign req.ready = idle && !rst;

  skt_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (req.valid),
    .req_in (req_in),
    .idle   (idle),
    .done   (done),
    .taken  (taken),
    .res    (res)
  );

  // output register is free when empty or being drained this cycle
  assign taken = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (done && taken) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
    if (done && taken) begin
      rsp.status      <= res.status;
      rsp.position    <= res.position;
      rsp.entry_total <= res.entry_total;
      if (res.report) begin
        rsp.found_building     <= building_letter(res.payload[16:15]);
        rsp.found_floor        <= res.payload[14:11];
        rsp.found_room         <= res.payload[10:4];
        rsp.found_kind         <= res.payload[3:2];
        rsp.found_availability <= res.payload[1:0];
      end else begin
        rsp.found_building     <= 8'd0;
        rsp.found_floor        <= 4'd0;
        rsp.found_room         <= 7'd0;
        rsp.found_kind         <= 2'd0;
        rsp.found_availability <= 2'd0;
      end
    end
  end
endmodule
`default_nettype wire

>>> design/skt_check.sv
// Port-level checks for the sorted key table, bound to the top level.
`default_nettype none
module skt_check (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [2:0] status,
  input logic [6:0] position,
  input logic [7:0] found_building,
  input logic [3:0] found_floor,
  input logic [6:0] found_room,
  input logic [1:0] found_kind,
  input logic [1:0] found_availability
);
  import skt_pkg::*;

  // one request at a time: ready drops right after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in progress");

  // a miss reports no record
  a_miss_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_NOT_FOUND |->
      found_building == 8'd0 && found_floor == 4'd0 && found_room == 7'd0 &&
      found_kind == 2'd0 && found_availability == 2'd0)
    else $error("record reported on a miss");

  // a successful request always reports a well-formed record
  a_ok_record: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_OK |->
      (found_building == CH_A || found_building == CH_B || found_building == CH_C) &&
      found_floor <= FLOOR_MAX)
    else $error("bad record on success");

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(position))
    else $error("response changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");
endmodule

bind sorted_key_table skt_check u_skt_check (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .status             (rsp.status),
  .position           (rsp.position),
  .found_building     (rsp.found_building),
  .found_floor        (rsp.found_floor),
  .found_room         (rsp.found_room),
  .found_kind         (rsp.found_kind),
  .found_availability (rsp.found_availability)
);
`default_nettype wire

>>> tb/skt_table_checker.sv
// Checker: watches both channels, predicts each table result and compares it.
`default_nettype none
module skt_table_checker #(
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  skt_req_if   req,
  skt_rsp_if   rsp,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import skt_pkg::*;

  typedef struct packed {
    logic [2:0]       status;
    logic [IDX_W-1:0] position;
    logic [IDX_W-1:0] entry_total;
    logic [7:0]       building;
    logic [3:0]       floor;
    logic [6:0]       room;
    logic [1:0]       kind;
    logic [1:0]       availability;
  } table_result_t;

  // shadow table: record = {building code, floor, room, kind, availability}
  logic [KEY_W-1:0] stored_keys [DEPTH];
  logic [PAY_W-1:0] stored_recs [DEPTH];
  int unsigned      stored_total;
  table_result_t    results_due [$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    stored_total = 0;
  end

  // lower bound search, same probe order as the block
  function automatic int unsigned find_slot(input logic [KEY_W-1:0] k, output bit hit);
    int unsigned lo, hi, mid;
    lo  = 0;
    hi  = stored_total;
    hit = 1'b0;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (stored_keys[mid] == k) begin
        hit = 1'b1;
        return mid;
      end
      if (k < stored_keys[mid]) hi = mid;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  function automatic table_result_t with_record(input table_result_t r,
                                                input logic [PAY_W-1:0] rec);
    table_result_t o;
    o = r;
    o.building     = (rec[16:15] == 2'd3) ? 8'd0 : CH_A + 8'(rec[16:15]);
    o.floor        = rec[14:11];
    o.room         = rec[10:4];
    o.kind         = rec[3:2];
    o.availability = rec[1:0];
    return o;
  endfunction

  task automatic apply_request(input logic [1:0] mode, input logic [KEY_W-1:0] key,
                               input logic [7:0] bch, input logic [3:0] flr,
                               input logic [6:0] room, input logic [1:0] kind,
                               input logic [1:0] avail, output table_result_t res);
    bit               hit;
    int unsigned      slot;
    bit               fields_ok;
    logic [7:0]       code;
    logic [PAY_W-1:0] rec;
    int unsigned      i;
    fields_ok = (bch == CH_A || bch == CH_B || bch == CH_C) && flr <= FLOOR_MAX;
    code      = bch - CH_A;
    rec       = {code[1:0], flr, room, kind, avail};
    slot      = find_slot(key, hit);
    res       = '0;
    case (mode)
      MODE_LOOKUP: begin
        if (hit) res = with_record(res, stored_recs[slot]);
        else res.status = ST_NOT_FOUND;
      end
      MODE_INSERT: begin
        if (hit) begin
          res.status = ST_DUPLICATE;
          res = with_record(res, stored_recs[slot]);
        end else if (!fields_ok) begin
          res.status = ST_INVALID;
        end else if (stored_total >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (i = stored_total; i > slot; i--) begin
            stored_keys[i] = stored_keys[i-1];
            stored_recs[i] = stored_recs[i-1];
          end
          stored_keys[slot] = key;
          stored_recs[slot] = rec;
          stored_total++;
          res = with_record(res, rec);
        end
      end
      MODE_DELETE: begin
        if (!hit) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res = with_record(res, stored_recs[slot]);
          for (i = slot; i + 1 < stored_total; i++) begin
            stored_keys[i] = stored_keys[i+1];
            stored_recs[i] = stored_recs[i+1];
          end
          stored_total--;
        end
      end
      default: begin
        if (!hit) begin
          res.status = ST_NOT_FOUND;
        end else if (!fields_ok) begin
          res.status = ST_INVALID;
          res = with_record(res, stored_recs[slot]);
        end else begin
          stored_recs[slot] = rec;
          res = with_record(res, rec);
        end
      end
    endcase
    res.position    = slot[IDX_W-1:0];
    res.entry_total = stored_total[IDX_W-1:0];
  endtask

  always @(posedge clk) begin
    table_result_t want, got;
    bit            bad;
    if (rst) begin
      stored_total = 0;
      results_due.delete();
      pending = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.status, rsp.position, rsp.entry_total, rsp.found_building,
                rsp.found_floor, rsp.found_room, rsp.found_kind, rsp.found_availability};
        if (results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[chk] %0t: result with nothing outstanding: %p", $realtime, got);
        end else begin
          want = results_due.pop_front();
          bad = (got.status !== want.status) || (got.position !== want.position)
             || (got.entry_total !== want.entry_total) || (got.building !== want.building)
             || (got.floor !== want.floor) || (got.room !== want.room)
             || (got.kind !== want.kind) || (got.availability !== want.availability);
          if (bad) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("[chk] %0t: result mismatch", $realtime);
              $display("  exp %p", want);
              $display("  got %p", got);
            end
          end
        end
      end
      if (req.valid && req.ready) begin
        apply_request(req.mode, req.key, req.building_char, req.floor, req.room,
                      req.kind, req.availability, want);
        results_due.push_back(want);
      end
      pending = results_due.size();
    end
  end

  // anything still owed at the end is caught by the top's watchdog

endmodule
`default_nettype wire

>>> tb/tb_sorted_key_table.sv
// Testbench top: clock, reset, request stimulus, response backpressure, verdict.
`default_nettype none
module tb_sorted_key_table;
  timeunit 1ns;
  timeprecision 1ps;
  import skt_pkg::*;

  localparam int DEPTH    = 64;
  localparam int POOL_SZ  = 96;    // more keys than slots so the table fills up
  localparam int SETTLE   = 150;   // longer than the worst-case request latency
  localparam int IDLE_PCT = 27;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches;
  int   results_owed;
  logic req_took = 1'b0;
  bit   calm = 1'b0;                 // high: neither side idles

  logic [KEY_W-1:0] key_pool [POOL_SZ];

  skt_req_if req ();
  skt_rsp_if rsp ();

  sorted_key_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  skt_table_checker #(.DEPTH(DEPTH)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .fail_count (mismatches),
    .pending    (results_owed)
  );

  always #5ns clk = ~clk;

  // Record a request transfer at the edge; the driver looks at it on the
  // following falling edge, so there is no race with the block's registers.
  always @(posedge clk) begin
    req_took <= req.valid && req.ready;
  end

  // Response side: stall ~27% of cycles unless in the calm stretch.
  initial rsp.ready = 1'b0;
  always @(negedge clk) begin
    rsp.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Hand one request over: random idle gap first, then hold valid and the
  // payload until the transfer happens. Returns on the falling edge right
  // after the accepting edge, with valid still high.
  task automatic issue(input logic [1:0] mode, input logic [31:0] key,
                       input logic [7:0] bch, input logic [3:0] flr,
                       input logic [6:0] room, input logic [1:0] kind,
                       input logic [1:0] avail);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid         <= 1'b1;
    req.mode          <= mode;
    req.key           <= key;
    req.building_char <= bch;
    req.floor         <= flr;
    req.room          <= room;
    req.kind          <= kind;
    req.availability  <= avail;
    do @(negedge clk); while (!req_took);
  endtask

  // Stop sending and wait until every outstanding result has come back.
  task automatic drain_results();
    req.valid <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);
  endtask

  // One random request. Mostly well-formed: pool keys, valid building and
  // floor; a slice of noise with arbitrary keys and fields.
  task automatic random_request(input int ins_pct, input int del_pct);
    logic [1:0]  mode;
    logic [31:0] key;
    logic [7:0]  bch;
    logic [3:0]  flr;
    logic [6:0]  room;
    int          r;
    r = $urandom_range(99);
    if (r < ins_pct) mode = MODE_INSERT;
    else if (r < ins_pct + del_pct) mode = MODE_DELETE;
    else if ($urandom_range(1) == 0) mode = MODE_LOOKUP;
    else mode = MODE_MODIFY;
    if ($urandom_range(99) < 8) key = $urandom;
    else key = key_pool[$urandom_range(POOL_SZ-1)];
    if ($urandom_range(99) < 10) begin
      // fully random fields, mostly invalid building or floor
      bch  = 8'($urandom_range(255));
      flr  = 4'($urandom_range(15));
      room = 7'($urandom_range(127));
    end else begin
      bch  = CH_A + 8'($urandom_range(2));
      flr  = 4'($urandom_range(8));
      room = ($urandom_range(99) < 5) ? 7'($urandom_range(127)) : 7'($urandom_range(99));
    end
    if ($urandom_range(99) < 5) mode = 2'($urandom_range(3));
    issue(mode, key, bch, flr, room, 2'($urandom_range(3)), 2'($urandom_range(3)));
  endtask

  initial begin
    // every block input known from time zero
    req.valid         = 1'b0;
    req.mode          = MODE_LOOKUP;
    req.key           = '0;
    req.building_char = '0;
    req.floor         = '0;
    req.room          = '0;
    req.kind          = '0;
    req.availability  = '0;

    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SZ; i++) begin
      key_pool[i] = {CH_A + 8'($urandom_range(25)), CH_A + 8'($urandom_range(25)),
                     CH_A + 8'($urandom_range(25)), CH_A + 8'($urandom_range(25))};
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed part ---
    // empty table: every kind of miss
    issue(MODE_LOOKUP, 32'h4D4D4D4D, CH_A, 4'd0, 7'd0, 2'd0, 2'd0);
    issue(MODE_DELETE, 32'h4D4D4D4D, CH_A, 4'd0, 7'd0, 2'd0, 2'd0);
    issue(MODE_MODIFY, 32'h4D4D4D4D, CH_B, 4'd3, 7'd10, 2'd1, 2'd1);
    // first entry, then a duplicate of it
    issue(MODE_INSERT, 32'h4D4D4D4D, CH_A, 4'd0, 7'd0, 2'd0, 2'd0);
    issue(MODE_INSERT, 32'h4D4D4D4D, CH_B, 4'd1, 7'd5, 2'd1, 2'd2);
    // insert at the end (largest key) and at the front (smallest key)
    issue(MODE_INSERT, 32'hFFFFFFFF, CH_C, FLOOR_MAX, 7'd127, 2'd3, 2'd3);
    issue(MODE_INSERT, 32'h00000000, CH_B, FLOOR_MAX, 7'd99, 2'd2, 2'd1);
    // bad building, bad floor, both, and an all-ones building byte
    issue(MODE_INSERT, 32'h4D4D4D4E, 8'h44, 4'd2, 7'd1, 2'd0, 2'd0);
    issue(MODE_INSERT, 32'h4D4D4D4E, CH_A, 4'd9, 7'd1, 2'd0, 2'd0);
    issue(MODE_INSERT, 32'h4D4D4D4E, 8'h00, 4'd15, 7'd1, 2'd0, 2'd0);
    issue(MODE_INSERT, 32'h4D4D4D4E, 8'hFF, 4'd0, 7'd1, 2'd0, 2'd0);
    // duplicate check wins over the field check
    issue(MODE_INSERT, 32'h4D4D4D4D, 8'h5A, 4'd12, 7'd3, 2'd0, 2'd0);
    issue(MODE_LOOKUP, 32'h4D4D4D4D, CH_A, 4'd0, 7'd0, 2'd0, 2'd0);
    issue(MODE_LOOKUP, 32'h4D4D4D4E, CH_A, 4'd0, 7'd0, 2'd0, 2'd0);
    issue(MODE_LOOKUP, 32'h7FFFFFFF, CH_A, 4'd0, 7'd0, 2'd0, 2'd0);
    // modify: good fields, bad fields on a present key, missing key
    issue(MODE_MODIFY, 32'h4D4D4D4D, CH_C, 4'd7, 7'd42, 2'd1, 2'd2);
    issue(MODE_MODIFY, 32'h4D4D4D4D, CH_A, 4'd12, 7'd11, 2'd3, 2'd3);
    issue(MODE_MODIFY, 32'h4D4D4D4E, 8'h51, 4'd13, 7'd11, 2'd3, 2'd3);
    // delete first, last, missing, and the only one left
    issue(MODE_DELETE, 32'h00000000, CH_A, 4'd0, 7'd0, 2'd0, 2'd0);
    issue(MODE_DELETE, 32'hFFFFFFFF, CH_A, 4'd0, 7'd0, 2'd0, 2'd0);
    issue(MODE_DELETE, 32'hFFFFFFFF, CH_A, 4'd0, 7'd0, 2'd0, 2'd0);
    issue(MODE_DELETE, 32'h4D4D4D4D, CH_A, 4'd0, 7'd0, 2'd0, 2'd0);
    issue(MODE_LOOKUP, 32'h00000000, CH_A, 4'd0, 7'd0, 2'd0, 2'd0);
    drain_results();

    // --- random part ---
    // Each round fills the table (runs into the full case with a 96 key
    // pool), churns it, then drains it. Round 1 fill runs with no idling.
    for (int round = 0; round < 3; round++) begin
      calm = (round == 1);
      repeat (170) random_request(78, 4);
      calm = 1'b0;
      drain_results();
      repeat (60) random_request(30, 30);
      repeat (130) random_request(10, 70);
      drain_results();
    end

    // done sending; wait for the tail and a little extra for strays
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // watchdog: a hung run ends as a failure
  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire
